// ===== hdl/bfwm_pkg.sv =====
// bfwm_pkg: shared types, constants and a case folding helper for the bloom filter
// depends on nothing
package bfwm_pkg;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_N  = 32'he6546b64;
  localparam logic [31:0] FM_C1 = 32'h85ebca6b;
  localparam logic [31:0] FM_C2 = 32'hc2b2ae35;
  localparam int          NUM_SEEDS = 6;

  localparam logic [2:0] REG_FILTER_BITS = 3'd0;
  localparam logic [2:0] REG_HASH_COUNT  = 3'd1;
  localparam logic [2:0] REG_SEED_ZERO   = 3'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // byte after case folding
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) r = b + 8'h20;
    return r;
  endfunction

  // word-end job handed from the front part to the back part
  typedef struct packed {
    logic                       op;
    logic [NUM_SEEDS-1:0][31:0] acc;
    logic [23:0]                tail;
    logic [1:0]                 tail_cnt;
    logic [31:0]                len;
  } bfwm_job_t;

endpackage

// ===== hdl/bfwm_ram.sv =====
// bfwm_ram: generic single port ram with registered read
// depends on nothing
module bfwm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/bfwm_front.sv =====
// bfwm_front: byte intake, case folding and murmur3 block mixing
// depends on bfwm_pkg
module bfwm_front
  import bfwm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       operation,
  input  logic [7:0]                 char_byte,
  input  logic                       has_byte,
  input  logic                       last_char,
  input  logic [NUM_SEEDS-1:0][15:0] seeds,
  input  logic                       q_full,
  output logic                       busy,
  output logic                       job_valid,
  output bfwm_job_t                  job
);
  // a byte that completes a 4-byte block goes through 3 sequential steps of a shared scramble:
  // step 1: k*c1, step 2: rot, *c2, step 3: per-lane xor/rot/*5+n
  typedef enum logic [1:0] {ST_IDLE, ST_MUL1, ST_MUL2, ST_MIX} fst_t;
  fst_t state_r;

  logic [NUM_SEEDS-1:0][31:0] acc_r;
  logic [23:0] tail_r;
  logic [1:0]  tcnt_r;
  logic [31:0] len_r;
  logic        active_r;
  logic        pend_end_r;
  logic        op_r;
  logic [31:0] k_r;
  logic        job_valid_r;

  logic [7:0]  fb;
  logic [NUM_SEEDS-1:0][31:0] acc_base;
  logic [31:0] k_rot;
  logic        take;

  assign fb   = fold_case(char_byte);
  assign take = in_valid && !busy;
  assign busy = (state_r != ST_IDLE) || pend_end_r;
  assign k_rot = {k_r[16:0], k_r[31:17]};

  always_comb begin
    for (int i = 0; i < NUM_SEEDS; i++)
      acc_base[i] = active_r ? acc_r[i] : {16'd0, seeds[i]};
  end

  assign job_valid = job_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      tcnt_r      <= 2'd0;
      tail_r      <= '0;
      len_r       <= '0;
      pend_end_r  <= 1'b0;
      job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (pend_end_r && !q_full) begin
            job_valid_r  <= 1'b1;
            job.op       <= op_r;
            job.acc      <= acc_base;
            job.tail     <= tail_r;
            job.tail_cnt <= tcnt_r;
            job.len      <= len_r;
            pend_end_r   <= 1'b0;
            active_r     <= 1'b0;
            tail_r       <= '0;
            tcnt_r       <= 2'd0;
            len_r        <= '0;
          end else if (take) begin
            op_r       <= operation;
            pend_end_r <= !has_byte || last_char;
            if (has_byte) begin
              if (!active_r) acc_r <= acc_base;
              active_r <= 1'b1;
              len_r    <= len_r + 32'd1;
              if (tcnt_r == 2'd3) begin
                k_r     <= ({fb, tail_r} * MM_C1);
                tail_r  <= '0;
                tcnt_r  <= 2'd0;
                state_r <= ST_MUL2;
              end else begin
                tail_r <= tail_r | (24'(fb) << (5'd8 * 5'(tcnt_r)));
                tcnt_r <= tcnt_r + 2'd1;
              end
            end
          end
        end
        ST_MUL1: state_r <= ST_MUL2;
        ST_MUL2: begin
          k_r     <= k_rot * MM_C2;
          state_r <= ST_MIX;
        end
        ST_MIX: begin
          for (int i = 0; i < NUM_SEEDS; i++) begin
            acc_r[i] <= ({acc_r[i][18:0] ^ k_r[18:0], acc_r[i][31:19] ^ k_r[31:19]}
                         * 32'd5) + MM_N;
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/bfwm_back.sv =====
// bfwm_back: tail scramble, finalization, modulo and bit store access
// depends on bfwm_pkg, bfwm_ram
module bfwm_back
  import bfwm_pkg::*;
#(
  parameter int MAX_FILTER_BITS = 65536,
  parameter int MAX_HASHES      = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  bfwm_job_t job,
  output logic      job_take,
  input  logic [16:0] filter_bits,
  input  logic [2:0]  hash_count,
  output logic      busy,
  output logic      out_valid,
  output logic      is_member,
  output logic      op_done
);
  localparam int AW = $clog2(MAX_FILTER_BITS);
  localparam int MW = AW + 1;
  localparam int HW = $clog2(MAX_HASHES + 1);

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_TK1, B_TK2, B_TK3, B_F1, B_F2, B_F3, B_F4,
    B_MOD, B_ACC, B_RD, B_DONE
  } bst_t;
  bst_t state_r;

  bfwm_job_t job_r;
  logic [31:0] h_r, k_r;
  logic [HW-1:0] hi_r, n_r;
  logic [MW-1:0] m_r;
  logic [31:0]   rem_r;
  logic [5:0]    mbit_r;
  logic [AW-1:0] clr_r;
  logic          member_r;
  logic          out_valid_r, is_member_r, op_done_r;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic          ram_wd, ram_rd;
  logic [32:0]   rem_sh;
  logic [32:0]   rem_try;

  bfwm_ram #(.WIDTH(1), .DEPTH(MAX_FILTER_BITS)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  // restoring modulo, one bit per cycle
  assign rem_sh  = {rem_r, h_r[31]};
  assign rem_try = rem_sh - 33'(m_r);

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = rem_r[AW-1:0];
    ram_wd   = 1'b1;
    if (state_r == B_CLEAR) begin
      ram_we = 1'b1; ram_addr = clr_r; ram_wd = 1'b0;
    end else if (state_r == B_ACC) begin
      ram_we = (job_r.op == OP_INSERT);
    end
  end

  assign busy      = (state_r != B_IDLE);
  assign job_take  = (state_r == B_IDLE) && job_valid;
  assign out_valid = out_valid_r;
  assign is_member = is_member_r;
  assign op_done   = op_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        B_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(MAX_FILTER_BITS - 1)) state_r <= B_IDLE;
        end
        B_IDLE: if (job_valid) begin
          job_r    <= job;
          hi_r     <= '0;
          member_r <= 1'b1;
          if (hash_count == 3'd0) n_r <= HW'(1);
          else if (32'(hash_count) > MAX_HASHES) n_r <= HW'(MAX_HASHES);
          else n_r <= HW'(hash_count);
          if (filter_bits == 17'd0) m_r <= MW'(1);
          else if (32'(filter_bits) > MAX_FILTER_BITS) m_r <= MW'(MAX_FILTER_BITS);
          else m_r <= MW'(filter_bits);
          k_r     <= 32'({8'd0, job.tail}) * MM_C1;
          state_r <= B_TK1;
        end
        B_TK1: begin
          k_r     <= {k_r[16:0], k_r[31:17]} * MM_C2;
          state_r <= B_TK2;
        end
        B_TK2: begin
          h_r     <= job_r.acc[hi_r] ^ (job_r.tail_cnt != 2'd0 ? k_r : 32'd0)
                     ^ job_r.len;
          state_r <= B_TK3;
        end
        B_TK3: begin
          h_r     <= (h_r ^ (h_r >> 16)) * FM_C1;
          state_r <= B_F1;
        end
        B_F1: begin
          h_r     <= (h_r ^ (h_r >> 13)) * FM_C2;
          state_r <= B_F2;
        end
        B_F2: begin
          h_r     <= h_r ^ (h_r >> 16);
          rem_r   <= '0;
          mbit_r  <= '0;
          state_r <= B_MOD;
        end
        B_MOD: begin
          if (!rem_try[32]) rem_r <= rem_try[31:0];
          else rem_r <= rem_sh[31:0];
          h_r    <= {h_r[30:0], 1'b0};
          mbit_r <= mbit_r + 6'd1;
          if (mbit_r == 6'd31) state_r <= B_ACC;
        end
        B_ACC: state_r <= B_RD;
        B_RD: begin
          if (job_r.op == OP_QUERY && !ram_rd) member_r <= 1'b0;
          if (hi_r + 1'b1 == n_r) state_r <= B_DONE;
          else begin
            hi_r    <= hi_r + 1'b1;
            state_r <= B_TK2;
          end
        end
        B_DONE: begin
          out_valid_r <= 1'b1;
          is_member_r <= member_r;
          op_done_r   <= job_r.op;
          state_r     <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/bfwm_queue.sv =====
// bfwm_queue: two entry job queue between front and back parts
// depends on bfwm_pkg
module bfwm_queue
  import bfwm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  bfwm_job_t push_job,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output bfwm_job_t head
);
  bfwm_job_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_job;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== hdl/bloom_filter_word_membership.sv =====
// bloom_filter_word_membership: top level of the word bloom filter
// a byte item that completes a 4-byte block runs the second multiply and then the
// per-seed mix in the front part; a word end runs the tail scramble and then, per hash,
// the finalize steps, a bit-serial modulo and a store access in the back part
// reset: synchronous; the bit store is cleared by a pass over every address after
// reset during which busy stays high; results cannot be stalled
module bloom_filter_word_membership
  import bfwm_pkg::*;
#(
  parameter int MAX_FILTER_BITS = 65536,
  parameter int MAX_HASHES      = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [7:0]  in_char_byte,
  input  logic        in_has_byte,
  input  logic        in_last_char,
  output logic        out_valid,
  output logic        out_is_member,
  output logic        out_op_done,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);
  // configuration registers
  logic [16:0] filter_bits_r;
  logic [2:0]  hash_count_r;
  logic [NUM_SEEDS-1:0][15:0] seeds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_bits_r <= 17'd65536;
      hash_count_r  <= 3'd3;
      for (int i = 0; i < NUM_SEEDS; i++) seeds_r[i] <= 16'(i);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_BITS: filter_bits_r <= cfg_wdata;
        REG_HASH_COUNT:  hash_count_r  <= cfg_wdata[2:0];
        default: seeds_r[cfg_index - REG_SEED_ZERO] <= cfg_wdata[15:0];
      endcase
    end
  end

  logic      front_busy, back_busy, q_full, q_ne, job_push, job_take;
  bfwm_job_t job_f, job_q;
  logic      rst_clr_r;
  logic [$clog2(MAX_FILTER_BITS):0] clr_cnt_r;

  // the front stalls while its block mix runs, a word end is staged or the queue is full;
  // it sees an item only at an edge where the whole block accepts it
  bfwm_front u_front (
    .clk, .rst_n, .in_valid(start && !busy), .operation(in_operation),
    .char_byte(in_char_byte), .has_byte(in_has_byte), .last_char(in_last_char),
    .seeds(seeds_r), .q_full, .busy(front_busy), .job_valid(job_push), .job(job_f)
  );

  bfwm_queue u_queue (
    .clk, .rst_n, .push(job_push), .push_job(job_f), .pop(job_take),
    .full(q_full), .not_empty(q_ne), .head(job_q)
  );

  bfwm_back #(.MAX_FILTER_BITS(MAX_FILTER_BITS), .MAX_HASHES(MAX_HASHES)) u_back (
    .clk, .rst_n, .job_valid(q_ne), .job(job_q), .job_take,
    .filter_bits(filter_bits_r), .hash_count(hash_count_r), .busy(back_busy),
    .out_valid, .is_member(out_is_member), .op_done(out_op_done)
  );

  // the front may stage a word end, so hold off while the queue has no room;
  // the store clear pass after reset also holds off new items
  assign busy = front_busy || q_full || rst_clr_r;

  // tracks the back part's clear pass, same length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_clr_r <= 1'b1;
      clr_cnt_r <= '0;
    end else if (rst_clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ($clog2(MAX_FILTER_BITS)+1)'(MAX_FILTER_BITS - 1)) rst_clr_r <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && q_full)) else $error("job pushed into a full queue");
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");
  a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    rst_clr_r |-> busy && back_busy) else $error("item taken during store clear");
`endif
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for bloom_filter_word_membership
// needs bfwm_pkg and the block itself; predicts membership answers with its own hash model
module tb;
  import bfwm_pkg::*;

  localparam int STORE_SIZE   = 65536;
  localparam int WATCH_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 400;

  typedef struct {
    logic       op;
    logic [7:0] b;
    logic       has;
    logic       last;
  } item_t;

  typedef struct {
    logic member;
    logic op;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_operation = 1'b0;
  logic [7:0]  in_char_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_last_char = 1'b0;
  logic        out_valid;
  logic        out_is_member;
  logic        out_op_done;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [16:0] cfg_wdata = 17'd0;

  bloom_filter_word_membership uut (.*);

  always #10 clk = ~clk;

  // stimulus and scoreboard storage
  item_t   pending_items[$];
  answer_t expected_answers[$];
  item_t   cur_item;
  int      idle_pct = 30;
  bit      hold_off = 1'b0;
  int      n_accepted = 0;
  int      n_answers = 0;
  int      n_hits = 0;
  int      n_errors = 0;
  int      n_pushed = 0;
  int      watch_cnt = 0;

  // configuration as the filter sees it
  logic [16:0] size_reg;
  logic [2:0]  nhash_reg;
  logic [15:0] seed_reg[0:5];

  // hash state of the word in progress
  bit          filter_bits_mem[0:STORE_SIZE-1];
  logic [31:0] acc[0:5];
  logic [23:0] tail_acc;
  logic [1:0]  tail_len;
  logic [31:0] word_len;
  bit          word_open;

  // words already inserted, reused for queries that should hit
  logic [7:0] lib_bytes[0:63][0:31];
  int         lib_len[0:63];
  int         lib_n = 0;

  function automatic logic [31:0] rol32(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mix_block(logic [31:0] k);
    k = k * 32'hcc9e2d51;
    k = rol32(k, 15);
    return k * 32'h1b873593;
  endfunction

  function automatic logic [31:0] avalanche(logic [31:0] h);
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    return h ^ (h >> 16);
  endfunction

  task automatic clear_word_state();
    for (int i = 0; i < 6; i++) acc[i] = 32'd0;
    tail_acc = 24'd0;
    tail_len = 2'd0;
    word_len = 32'd0;
    word_open = 1'b0;
  endtask

  task automatic take_seeds();
    for (int i = 0; i < 6; i++) acc[i] = {16'd0, seed_reg[i]};
  endtask

  // one accepted item: update hashes, and on a word end compute the answer
  task automatic predict_membership(item_t it);
    logic [31:0] b, k, h, idx, m;
    int          n;
    bit          member;
    answer_t     ans;
    if (it.has) begin
      if (!word_open) begin
        take_seeds();
        word_open = 1'b1;
      end
      b = {24'd0, it.b};
      if (b >= 32'h41 && b <= 32'h5a) b = b + 32'h20;
      word_len = word_len + 32'd1;
      if (tail_len == 2'd3) begin
        k = mix_block({b[7:0], tail_acc});
        for (int i = 0; i < 6; i++) begin
          h = rol32(acc[i] ^ k, 13);
          acc[i] = h * 32'd5 + 32'he6546b64;
        end
        tail_acc = 24'd0;
        tail_len = 2'd0;
      end else begin
        tail_acc = tail_acc | (b[23:0] << (8 * tail_len));
        tail_len = tail_len + 2'd1;
      end
      if (!it.last) return;
    end
    if (!word_open) take_seeds();
    n = (nhash_reg == 3'd0) ? 1 : (nhash_reg > 3'd6) ? 6 : int'(nhash_reg);
    m = (size_reg == 17'd0) ? 32'd1 : (size_reg > 17'd65536) ? 32'd65536 : {15'd0, size_reg};
    member = 1'b1;
    for (int i = 0; i < n; i++) begin
      h = acc[i];
      if (tail_len != 2'd0) h = h ^ mix_block({8'd0, tail_acc});
      h = avalanche(h ^ word_len);
      idx = h % m;
      if (it.op == OP_INSERT) filter_bits_mem[idx] = 1'b1;
      else if (!filter_bits_mem[idx]) member = 1'b0;
    end
    clear_word_state();
    ans = '{member, it.op};
    expected_answers.insert(expected_answers.size(), ans);
  endtask

  // driver: start stays high until the block takes the item
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_membership(cur_item);
        n_accepted++;
      end
      if (!start || !busy) begin
        if (!hold_off && pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_item = pending_items.pop_front();
          start <= 1'b1;
          in_operation <= cur_item.op;
          in_char_byte <= cur_item.b;
          in_has_byte <= cur_item.has;
          in_last_char <= cur_item.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed answer is checked against the oldest prediction
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      n_answers++;
      if (expected_answers.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected answer member=%0b op=%0b", out_is_member,
                                     out_op_done);
      end else begin
        want = expected_answers.pop_front();
        if (want.op == OP_QUERY && want.member) n_hits++;
        if (out_is_member !== want.member || out_op_done !== want.op) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: expected member=%0b op=%0b, got member=%0b op=%0b",
                     want.member, want.op, out_is_member, out_op_done);
        end
      end
    end
  end

  // watchdog on cycles with no traffic in either direction
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_valid) watch_cnt <= 0;
    else watch_cnt <= watch_cnt + 1;
    if (watch_cnt == WATCH_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_FILTER_BITS) size_reg = val;
    else if (idx == REG_HASH_COUNT) nhash_reg = val[2:0];
    else seed_reg[idx - REG_SEED_ZERO] = val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every item taken and every answer in, then let the back end settle
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() > 0 || start || expected_answers.size() > 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic push_item(logic op, logic [7:0] b, logic has, logic last);
    item_t it;
    it = '{op, b, has, last};
    pending_items.insert(pending_items.size(), it);
    n_pushed++;
  endtask

  // a word from a string; a null end marker closes it instead of the last flag
  task automatic push_text(string s, logic op, bit null_end);
    for (int i = 0; i < s.len(); i++)
      push_item(op, s[i], 1'b1, !null_end && i == s.len() - 1);
    if (null_end || s.len() == 0) push_item(op, 8'h00, 1'b0, 1'b0);
  endtask

  // random word: mostly letters, sometimes raw bytes, queries often reuse inserted words
  task automatic push_random_word();
    logic [7:0] w[0:31];
    int         len, pick;
    logic       op;
    bit         null_end;
    op = 1'($urandom_range(1));
    if ($urandom_range(9) < 8) len = $urandom_range(7);
    else len = $urandom_range(24, 8);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: w[i] = 8'(8'h41 + $urandom_range(25));
        1, 2: w[i] = 8'(8'h61 + $urandom_range(25));
        default: w[i] = 8'($urandom_range(255));
      endcase
    end
    if (op == OP_QUERY && lib_n > 0 && $urandom_range(1)) begin
      pick = $urandom_range(lib_n - 1);
      len = lib_len[pick];
      for (int i = 0; i < len; i++) w[i] = lib_bytes[pick][i];
    end
    if (op == OP_INSERT && lib_n < 64) begin
      lib_len[lib_n] = len;
      for (int i = 0; i < len; i++) lib_bytes[lib_n][i] = w[i];
      lib_n++;
    end
    null_end = (len == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < len; i++)
      push_item(1'($urandom_range(1)), w[i], 1'b1, !null_end && i == len - 1);
    if (null_end) push_item(op, 8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
    else pending_items[$].op = op;
  endtask

  task automatic random_run(int count);
    int stop_at;
    stop_at = n_pushed + count;
    while (n_pushed < stop_at) begin
      if ($urandom_range(9) == 0) begin
        // noise: a random byte that may or may not end a word
        push_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else begin
        push_random_word();
      end
    end
  endtask

  task automatic random_seeds();
    for (int i = 0; i < 6; i++)
      write_reg(REG_SEED_ZERO + 3'(i), 17'($urandom_range(17'h1ffff)));
  endtask

  initial begin
    size_reg = 17'd65536;
    nhash_reg = 3'd3;
    for (int i = 0; i < 6; i++) seed_reg[i] = 16'(i);
    for (int i = 0; i < STORE_SIZE; i++) filter_bits_mem[i] = 1'b0;
    clear_word_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under reset settings, sender idles 30 percent
    push_text("", OP_QUERY, 0);
    push_text("", OP_INSERT, 0);
    push_text("", OP_QUERY, 0);
    push_text("HeLLo", OP_INSERT, 0);
    push_text("hello", OP_QUERY, 0);
    push_text("AZaz@[", OP_INSERT, 1);
    push_text("azaz@[", OP_QUERY, 0);
    push_text("abcd", OP_QUERY, 0);
    push_item(OP_INSERT, 8'h00, 1'b1, 1'b0);
    push_item(OP_INSERT, 8'hff, 1'b1, 1'b1);
    push_text("xyz", OP_QUERY, 1);
    drain();

    // every register, small filter so bits collide
    write_reg(REG_FILTER_BITS, 17'd64);
    write_reg(REG_HASH_COUNT, 17'd6);
    random_seeds();
    random_run(120);
    // halfway through, pause until every answer is in
    while (pending_items.size() > 60) @(posedge clk);
    hold_off = 1'b1;
    do @(posedge clk);
    while (start || expected_answers.size() > 0);
    hold_off = 1'b0;
    drain();

    // degenerate sizes: filter of one bit, one hash
    write_reg(REG_FILTER_BITS, 17'd0);
    write_reg(REG_HASH_COUNT, 17'd0);
    random_run(30);
    drain();

    // oversized filter and hash count clamp to their maxima; sender idles more
    idle_pct = 55;
    write_reg(REG_FILTER_BITS, 17'h1ffff);
    write_reg(REG_HASH_COUNT, 17'd7);
    random_seeds();
    random_run(110);
    drain();
    // seed write between bytes of one word only counts from the next word
    push_text("se", OP_INSERT, 0);
    pending_items[$].last = 1'b0;
    drain();
    write_reg(REG_SEED_ZERO, 17'h0abcd);
    push_item(OP_INSERT, "d", 1'b1, 1'b1);
    push_text("sed", OP_QUERY, 0);
    push_text("", OP_QUERY, 0);
    drain();

    // mid-size filter, sender never idles
    idle_pct = 0;
    write_reg(REG_FILTER_BITS, 17'd1000);
    write_reg(REG_HASH_COUNT, 17'd2);
    random_seeds();
    random_run(110);
    drain();

    $display("covered %0d items, %0d answers (%0d query hits), %0d mismatches",
             n_accepted, n_answers, n_hits, n_errors);
    $display("filter sizes 1..65536 with clamping, 1..6 hashes, seed changes mid word");
    if (n_errors == 0 && expected_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
